@@ rtl/fse_pkg.sv @@
// Package with the types, opcodes and hash constants shared by the flow sketch encoder.
package fse_pkg;

  localparam int unsigned DefBloomAddrBits = 16;
  localparam int unsigned DefTableAddrBits = 12;
  localparam int unsigned DefHashCount     = 4;

  // Widest clear address and hash index that any legal parameter set needs.
  localparam int unsigned ClrAddrW = 24;
  localparam int unsigned IdxW     = 3;

  localparam logic [31:0] MurC1   = 32'hcc9e2d51;
  localparam logic [31:0] MurC2   = 32'h1b873593;
  localparam logic [31:0] MurMixC = 32'he6546b64;
  localparam logic [31:0] MurF1   = 32'h85ebca6b;
  localparam logic [31:0] MurF2   = 32'hc2b2ae35;
  localparam logic [31:0] KeyLen  = 32'd13;

  localparam logic OpEncode = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [11:0] bucket_index;
  } in_t;

  typedef struct packed {
    logic        new_flow;
    logic [63:0] flow_xor;
    logic [31:0] flow_count;
    logic [31:0] packet_count;
  } res_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_KMUL1,
    DP_KMUL2,
    DP_HINIT,
    DP_HMIX,
    DP_HTAIL,
    DP_FMUL1,
    DP_FMUL2,
    DP_BREAD,
    DP_BSET,
    DP_TREAD,
    DP_TWRITE,
    DP_RREAD,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e                op;
    logic [IdxW-1:0]       idx;
    logic [1:0]            sel;
    logic                  chk;
    logic [ClrAddrW-1:0]   clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_op;
    logic new_flow;
  } dp_stat_t;

endpackage

@@ rtl/flow_sketch_encoder.sv @@
// Top level of the flow sketch encoder: controller plus datapath.
// After reset the block clears both sketch memories, one address per cycle, over all
// 2**max(BLOOM_ADDR_BITS, TABLE_ADDR_BITS) addresses (65536 by default) with busy high.
// An encode runs key premix, hashing, Bloom reads, table updates and result, serialised by
// the one shared multiplier and single-port memories; a new flow also sets the Bloom bits.
// A bucket read passes dispatch, table read and result. One request at a time, the next can
// be accepted while done is high; the receiver cannot stall. Reset is asynchronous, low.
module flow_sketch_encoder #(
  parameter int unsigned BLOOM_ADDR_BITS = fse_pkg::DefBloomAddrBits,
  parameter int unsigned TABLE_ADDR_BITS = fse_pkg::DefTableAddrBits,
  parameter int unsigned HASH_COUNT      = fse_pkg::DefHashCount
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fse_pkg::in_t  in_i,
  output logic          done_o,
  output fse_pkg::res_t res_o
);
  import fse_pkg::*;

  localparam int unsigned ClrBits =
    (BLOOM_ADDR_BITS > TABLE_ADDR_BITS) ? BLOOM_ADDR_BITS : TABLE_ADDR_BITS;

  logic     accept;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign accept = start & ~busy;

  fse_ctrl #(
    .HASH_COUNT(HASH_COUNT),
    .CLR_BITS  (ClrBits)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  fse_datapath #(
    .BLOOM_ADDR_BITS(BLOOM_ADDR_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .HASH_COUNT     (HASH_COUNT)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(accept),
    .in_i  (in_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (res_o)
  );

endmodule

@@ rtl/fse_ram.sv @@
// Generic single-port RAM with registered read data.
module fse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fse_datapath.sv @@
// Datapath: tuple register, shared hash multiplier, hash store and the two sketch memories.
module fse_datapath #(
  parameter int unsigned BLOOM_ADDR_BITS = fse_pkg::DefBloomAddrBits,
  parameter int unsigned TABLE_ADDR_BITS = fse_pkg::DefTableAddrBits,
  parameter int unsigned HASH_COUNT      = fse_pkg::DefHashCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fse_pkg::in_t       in_i,
  input  fse_pkg::dp_cmd_t   cmd_i,
  output fse_pkg::dp_stat_t  stat_o,
  output fse_pkg::res_t      res_o
);
  import fse_pkg::*;

  localparam int unsigned HashIdxW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int unsigned TableW   = 128;

  in_t         in_q;
  res_t        res_q;
  logic        new_q;
  logic [31:0] k_q [4];
  logic [31:0] h_q;
  logic [31:0] hashes_q [HASH_COUNT];

  logic [31:0] key_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] mix_x;
  logic [31:0] mix_r;
  logic [31:0] tail_t;
  logic [31:0] cur_hash;
  logic [5:0]  seed;

  logic                       bloom_we;
  logic [BLOOM_ADDR_BITS-1:0] bloom_addr;
  logic [0:0]                 bloom_wdata;
  logic [0:0]                 bloom_rdata;

  logic                       table_we;
  logic [TABLE_ADDR_BITS-1:0] table_addr;
  logic [TableW-1:0]          table_wdata;
  logic [TableW-1:0]          table_rdata;
  logic [ClrAddrW-1:0]        rd_index;
  logic [63:0]                pair;

  assign cur_hash = hashes_q[cmd_i.idx[HashIdxW-1:0]];
  assign seed     = {3'b000, cmd_i.idx} * {3'b000, cmd_i.idx};
  assign pair     = {in_q.src_ip, in_q.dst_ip};
  assign rd_index = {{(ClrAddrW-12){1'b0}}, in_q.bucket_index};

  always_comb begin
    case (cmd_i.sel)
      2'd0:    key_val = in_q.src_ip;
      2'd1:    key_val = in_q.dst_ip;
      2'd2:    key_val = {in_q.dport, in_q.sport};
      default: key_val = {24'd0, in_q.protocol};
    endcase
  end

  // One 32x32 multiplier is shared by the key premix and the final mix.
  always_comb begin
    mul_a = h_q;
    mul_b = MurF1;
    case (cmd_i.op)
      DP_KMUL1: begin
        mul_a = key_val;
        mul_b = MurC1;
      end
      DP_KMUL2: begin
        mul_a = {k_q[cmd_i.sel][16:0], k_q[cmd_i.sel][31:17]};
        mul_b = MurC2;
      end
      DP_FMUL2: begin
        mul_b = MurF2;
      end
      default: begin
        mul_b = MurF1;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign mix_x  = h_q ^ k_q[cmd_i.sel];
  assign mix_r  = {mix_x[18:0], mix_x[31:19]};
  assign tail_t = h_q ^ k_q[3] ^ KeyLen;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      in_q <= in_i;
    end
    case (cmd_i.op)
      DP_KMUL1, DP_KMUL2: k_q[cmd_i.sel] <= prod;
      DP_HINIT:  h_q <= {26'd0, seed};
      DP_HMIX:   h_q <= {mix_r[29:0], 2'b00} + mix_r + MurMixC;
      DP_HTAIL:  h_q <= tail_t ^ {16'd0, tail_t[31:16]};
      DP_FMUL1:  h_q <= prod ^ {13'd0, prod[31:13]};
      DP_FMUL2:  hashes_q[cmd_i.idx[HashIdxW-1:0]] <= prod ^ {16'd0, prod[31:16]};
      default: begin
      end
    endcase
    if (cmd_i.op == DP_RESULT) begin
      if (in_q.opcode == OpRead) begin
        res_q.new_flow     <= 1'b0;
        res_q.flow_xor     <= table_rdata[127:64];
        res_q.flow_count   <= table_rdata[63:32];
        res_q.packet_count <= table_rdata[31:0];
      end else begin
        res_q.new_flow     <= new_q;
        res_q.flow_xor     <= '0;
        res_q.flow_count   <= '0;
        res_q.packet_count <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_q <= 1'b0;
    end else if (load_i) begin
      new_q <= 1'b0;
    end else if (cmd_i.chk && (bloom_rdata == 1'b0)) begin
      new_q <= 1'b1;
    end
  end

  always_comb begin
    bloom_we    = 1'b0;
    bloom_wdata = 1'b1;
    bloom_addr  = cur_hash[BLOOM_ADDR_BITS-1:0];
    if (cmd_i.op == DP_CLEAR) begin
      bloom_we    = 1'b1;
      bloom_wdata = 1'b0;
      bloom_addr  = cmd_i.clr_addr[BLOOM_ADDR_BITS-1:0];
    end else if (cmd_i.op == DP_BSET) begin
      bloom_we = new_q;
    end
  end

  always_comb begin
    table_we    = 1'b0;
    table_addr  = cur_hash[TABLE_ADDR_BITS-1:0];
    table_wdata = {table_rdata[127:64] ^ (new_q ? pair : 64'd0),
                   table_rdata[63:32] + {31'd0, new_q},
                   table_rdata[31:0] + 32'd1};
    case (cmd_i.op)
      DP_CLEAR: begin
        table_we    = 1'b1;
        table_addr  = cmd_i.clr_addr[TABLE_ADDR_BITS-1:0];
        table_wdata = '0;
      end
      DP_RREAD: table_addr = rd_index[TABLE_ADDR_BITS-1:0];
      DP_TWRITE: table_we = 1'b1;
      default: begin
      end
    endcase
  end

  fse_ram #(
    .WIDTH(1),
    .DEPTH(2 ** BLOOM_ADDR_BITS)
  ) u_bloom_ram (
    .clk_i  (clk_i),
    .we_i   (bloom_we),
    .addr_i (bloom_addr),
    .wdata_i(bloom_wdata),
    .rdata_o(bloom_rdata)
  );

  fse_ram #(
    .WIDTH(TableW),
    .DEPTH(2 ** TABLE_ADDR_BITS)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .addr_i (table_addr),
    .wdata_i(table_wdata),
    .rdata_o(table_rdata)
  );

  // The last Bloom bit arrives in the same cycle as the decision, so it is folded in here.
  assign stat_o.rd_op    = in_q.opcode;
  assign stat_o.new_flow = new_q | (cmd_i.chk & ~bloom_rdata[0]);
  assign res_o           = res_q;

endmodule

@@ rtl/fse_ctrl.sv @@
// Controller: clearing sweep and the per-request sequence of datapath steps.
module fse_ctrl #(
  parameter int unsigned HASH_COUNT = fse_pkg::DefHashCount,
  parameter int unsigned CLR_BITS   = fse_pkg::DefBloomAddrBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  fse_pkg::dp_stat_t stat_i,
  output fse_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import fse_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_KEY, S_HASH, S_BRD, S_BCHK,
    S_BSET, S_TRD, S_TWR, S_RRD, S_RESP
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(HASH_COUNT - 1);

  state_e             state_q;
  logic [CLR_BITS-1:0] clr_q;
  logic [IdxW-1:0]     idx_q;
  logic [2:0]          sub_q;
  logic                done_q;
  logic                last_idx;

  assign last_idx = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      sub_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx_q <= '0;
          sub_q <= '0;
          if (accept_i) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          state_q <= (stat_i.rd_op == OpRead) ? S_RRD : S_KEY;
        end
        S_KEY: begin
          sub_q <= sub_q + 3'd1;
          if (sub_q == 3'd7) begin
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          if (sub_q == 3'd6) begin
            sub_q <= '0;
            idx_q <= last_idx ? '0 : idx_q + 1'b1;
            if (last_idx) begin
              state_q <= S_BRD;
            end
          end else begin
            sub_q <= sub_q + 3'd1;
          end
        end
        S_BRD: begin
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
          if (last_idx) begin
            state_q <= S_BCHK;
          end
        end
        S_BCHK: begin
          state_q <= stat_i.new_flow ? S_BSET : S_TRD;
        end
        S_BSET: begin
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
          if (last_idx) begin
            state_q <= S_TRD;
          end
        end
        S_TRD: begin
          state_q <= S_TWR;
        end
        S_TWR: begin
          idx_q   <= last_idx ? '0 : idx_q + 1'b1;
          state_q <= last_idx ? S_RESP : S_TRD;
        end
        S_RRD: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.idx      = idx_q;
    cmd_o.clr_addr = ClrAddrW'(clr_q);
    unique case (state_q)
      S_CLEAR: cmd_o.op = DP_CLEAR;
      S_KEY: begin
        cmd_o.op  = sub_q[0] ? DP_KMUL2 : DP_KMUL1;
        cmd_o.sel = sub_q[2:1];
      end
      S_HASH: begin
        case (sub_q)
          3'd0:    cmd_o.op = DP_HINIT;
          3'd1, 3'd2, 3'd3: begin
            cmd_o.op  = DP_HMIX;
            cmd_o.sel = 2'(sub_q - 3'd1);
          end
          3'd4:    cmd_o.op = DP_HTAIL;
          3'd5:    cmd_o.op = DP_FMUL1;
          default: cmd_o.op = DP_FMUL2;
        endcase
      end
      S_BRD: begin
        cmd_o.op  = DP_BREAD;
        cmd_o.chk = (idx_q != '0);
      end
      S_BCHK:  cmd_o.chk = 1'b1;
      S_BSET:  cmd_o.op  = DP_BSET;
      S_TRD:   cmd_o.op  = DP_TREAD;
      S_TWR:   cmd_o.op  = DP_TWRITE;
      S_RRD:   cmd_o.op  = DP_RREAD;
      S_RESP:  cmd_o.op  = DP_RESULT;
      default: cmd_o.op  = DP_NOP;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> busy_o) else $error("accepted request did not start work");
  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> (done_q && !busy_o)) else $error("result not delivered");
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (busy_o && !done_q)) else $error("idle during clear");
`endif

endmodule

@@ tb/flow_sketch_encoder_test.sv @@
// Self-checking testbench for the flow sketch encoder: Bloom and bucket-table predictor.
`timescale 1ns / 1ps

module flow_sketch_encoder_test;
  import fse_pkg::*;

  localparam int unsigned BloomBits = DefBloomAddrBits;
  localparam int unsigned TableBits = DefTableAddrBits;
  localparam int unsigned NumHash   = DefHashCount;
  localparam int unsigned WatchLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic done_o;
  res_t res_o;

  flow_sketch_encoder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // Predictor state, mirrored from the sketch memories.
  bit          bloom_mirror [2**BloomBits];
  logic [63:0] xor_mirror   [2**TableBits];
  logic [31:0] flows_mirror [2**TableBits];
  logic [31:0] pkts_mirror  [2**TableBits];

  res_t        pending_results[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  bit          timed_out;

  // Recently encoded tuples, replayed so that Bloom hits actually occur.
  in_t         seen_tuples[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] scramble(logic [31:0] k);
    logic [31:0] t;
    t = k * MurC1;
    t = rotl(t, 15);
    return t * MurC2;
  endfunction

  function automatic logic [31:0] murmur_tuple(in_t p, logic [31:0] seed);
    logic [31:0] h;
    h = seed;
    h = rotl(h ^ scramble(p.src_ip), 13) * 32'd5 + MurMixC;
    h = rotl(h ^ scramble(p.dst_ip), 13) * 32'd5 + MurMixC;
    h = rotl(h ^ scramble({p.dport, p.sport}), 13) * 32'd5 + MurMixC;
    h = h ^ scramble({24'd0, p.protocol});
    h = h ^ KeyLen;
    h = h ^ (h >> 16);
    h = h * MurF1;
    h = h ^ (h >> 13);
    h = h * MurF2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic res_t predict_sketch(in_t p);
    res_t        r;
    logic [31:0] hv [NumHash];
    logic [63:0] pair;
    bit          fresh;
    int unsigned a;
    r = '0;
    if (p.opcode == OpRead) begin
      a = p.bucket_index & ((1 << TableBits) - 1);
      r.flow_xor     = xor_mirror[a];
      r.flow_count   = flows_mirror[a];
      r.packet_count = pkts_mirror[a];
      return r;
    end
    fresh = 1'b0;
    for (int i = 0; i < NumHash; i++) begin
      hv[i] = murmur_tuple(p, i * i);
      if (!bloom_mirror[hv[i] & ((1 << BloomBits) - 1)]) fresh = 1'b1;
    end
    pair = {p.src_ip, 32'd0} + {32'd0, p.dst_ip};
    for (int i = 0; i < NumHash; i++) begin
      a = hv[i] & ((1 << TableBits) - 1);
      if (fresh) begin
        bloom_mirror[hv[i] & ((1 << BloomBits) - 1)] = 1'b1;
        xor_mirror[a]   = xor_mirror[a] ^ pair;
        flows_mirror[a] = flows_mirror[a] + 32'd1;
      end
      pkts_mirror[a] = pkts_mirror[a] + 32'd1;
    end
    r.new_flow = fresh;
    return r;
  endfunction

  function automatic in_t random_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_t)-1:0];
  endfunction

  // Sends one request; the predicted result is queued at the accepting edge.
  task automatic send_request(in_t p);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    start <= 1'b1;
    in_i  <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_sketch(p));
    if (p.opcode == OpEncode) begin
      seen_tuples.push_back(p);
      if (seen_tuples.size() > 64) void'(seen_tuples.pop_front());
    end
    start <= 1'b0;
    in_i  <= random_item();
    // The block is busy after a transfer, so this edge costs no throughput.
    @(posedge clk_i);
  endtask

  function automatic in_t encode_of(logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                                    logic [15:0] dp, logic [7:0] pr);
    in_t p;
    p = random_item();
    p.opcode   = OpEncode;
    p.src_ip   = sip;
    p.dst_ip   = dip;
    p.sport    = sp;
    p.dport    = dp;
    p.protocol = pr;
    return p;
  endfunction

  function automatic in_t read_of(logic [11:0] idx);
    in_t p;
    p = random_item();
    p.opcode       = OpRead;
    p.bucket_index = idx;
    return p;
  endfunction

  function automatic in_t random_tuple();
    return encode_of($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  // Result checker: every done pulse is compared with the oldest prediction.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (res_o.new_flow !== exp_r.new_flow || res_o.flow_xor !== exp_r.flow_xor ||
            res_o.flow_count !== exp_r.flow_count ||
            res_o.packet_count !== exp_r.packet_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp nf=%0b xor=%h fc=%h pc=%h, got nf=%0b xor=%h fc=%h pc=%h",
                     exp_r.new_flow, exp_r.flow_xor, exp_r.flow_count, exp_r.packet_count,
                     res_o.new_flow, res_o.flow_xor, res_o.flow_count, res_o.packet_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; the clearing pass after reset fits well inside.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        timed_out = 1'b1;
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_request(read_of(12'd0));
    send_request(read_of(12'hfff));
    send_request(encode_of('0, '0, '0, '0, '0));
    send_request(encode_of('1, '1, '1, '1, '1));
    send_request(encode_of('0, '0, '0, '0, '0));
    send_request(encode_of(32'h80000000, 32'h00000001, 16'h8000, 16'h0001, 8'h80));
    send_request(encode_of(32'hc0a80001, 32'h0a000001, 16'd443, 16'd51000, 8'd6));
    send_request(encode_of(32'hc0a80001, 32'h0a000001, 16'd443, 16'd51000, 8'd6));
    send_request(encode_of(32'hc0a80001, 32'h0a000001, 16'd443, 16'd51000, 8'd17));
    for (int i = 0; i < 8; i++) send_request(read_of(12'($urandom)));
  endtask

  // Reads back every bucket of six randomly picked recent tuples, covering hash collisions.
  task automatic test_readback();
    in_t p;
    for (int n = 0; n < 6 && seen_tuples.size() > 0; n++) begin
      p = seen_tuples[$urandom_range(seen_tuples.size() - 1)];
      for (int i = 0; i < NumHash; i++) send_request(read_of(12'(murmur_tuple(p, i * i))));
    end
  endtask

  task automatic test_random(int unsigned count);
    int unsigned pick;
    in_t         p;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_request(random_tuple());
      end else if (pick < 65 && seen_tuples.size() > 0) begin
        p = seen_tuples[$urandom_range(seen_tuples.size() - 1)];
        p.bucket_index = 12'($urandom);
        send_request(p);
      end else if (pick < 75 && seen_tuples.size() > 0) begin
        p = seen_tuples[$urandom_range(seen_tuples.size() - 1)];
        send_request(read_of(12'(murmur_tuple(p, $urandom_range(NumHash - 1) ** 2))));
      end else begin
        send_request(read_of(12'($urandom)));
      end
    end
  endtask

  initial begin
    mismatches    = 0;
    timed_out     = 1'b0;
    send_idle_pct = 35;
    for (int i = 0; i < 2**BloomBits; i++) bloom_mirror[i] = 1'b0;
    for (int i = 0; i < 2**TableBits; i++) begin
      xor_mirror[i]   = '0;
      flows_mirror[i] = '0;
      pkts_mirror[i]  = '0;
    end
    start  <= 1'b0;
    in_i   <= '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_readback();
    // The sender holds off here until every prediction has been checked.
    wait_drained();
    test_random(365);
    send_idle_pct = 47;
    test_random(365);
    send_idle_pct = 0;
    test_random(365);
    test_readback();

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0 && !timed_out) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fse_pkg.sv
rtl/fse_ram.sv
rtl/fse_datapath.sv
rtl/fse_ctrl.sv
rtl/flow_sketch_encoder.sv
tb/flow_sketch_encoder_test.sv
